/* rtl/tpcl_pkg.sv */
`default_nettype none

package tpcl_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned SlotBits   = $clog2(MaxEntries);
  localparam int unsigned TotalBits  = $clog2(MaxEntries + 1);
  localparam int unsigned KeyBits    = 32;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned ThrBits    = 16;
  localparam int unsigned CapBits    = 5;
  localparam int unsigned CfgBits    = 16;

  // output word layout, lowest bit first: hit_count, evicted_key, occupancy
  localparam int unsigned OutFieldBits = CountBits + KeyBits + TotalBits;
  localparam int unsigned OutDataBits  = ((OutFieldBits + 7) / 8) * 8;
  localparam int unsigned OutPadBits   = OutDataBits - OutFieldBits;
  localparam int unsigned OccLsb       = CountBits + KeyBits;

  // output tuser layout, lowest bit first: hit, promoted, evicted
  localparam int unsigned UserHit      = 0;
  localparam int unsigned UserPromoted = 1;
  localparam int unsigned UserEvicted  = 2;
  localparam int unsigned OutUserBits  = 3;

  localparam logic [ThrBits-1:0] ThrReset = ThrBits'(2);
  localparam logic [CapBits-1:0] CapReset = CapBits'(16);

  typedef enum logic {
    CmdAccess = 1'b0,
    CmdClear  = 1'b1
  } cmd_e;

  typedef enum logic {
    RegThreshold = 1'b0,
    RegCapacity  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StUpd  = 3'b100
  } state_e;

endpackage

`default_nettype wire

/* rtl/threshold_promote_cache_list.sv */
// Threshold-promote cache list: list of page keys with hit counts. A miss puts
// its key at the front; a hit moves to the front once its count exceeds the
// threshold. Clear or an empty list goes straight to the update step; else the
// key memory is scanned one entry a cycle from the front to a hit or the last
// entry. Words are taken only in idle. Reset: list empty, threshold 2,
// capacity 16, slot order set to identity; key and count memories are not cleared.
`default_nettype none

module threshold_promote_cache_list (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  // configuration write channel
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire                           cfg_index_i,
  input  wire  [tpcl_pkg::CfgBits-1:0]  cfg_data_i,
  // input stream
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire  [tpcl_pkg::KeyBits-1:0]  s_axis_tdata,   // [31:0] page_key
  input  wire                           s_axis_tuser,   // [0] cmd
  // result stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [tpcl_pkg::OutDataBits-1:0]  m_axis_tdata,  // hit_count, evicted_key, occupancy
  output logic [tpcl_pkg::OutUserBits-1:0]  m_axis_tuser   // hit, promoted, evicted
);
  import tpcl_pkg::*;

  // Configuration registers; always ready, a write takes effect at the next edge.
  logic [ThrBits-1:0] thr_q;
  logic [CapBits-1:0] cap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
      cap_q <= CapReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegThreshold: thr_q <= cfg_data_i[ThrBits-1:0];
        RegCapacity:  cap_q <= cfg_data_i[CapBits-1:0];
        default:      ;
      endcase
    end
  end

  // Clamp capacity into 1..MaxEntries.
  logic [TotalBits-1:0] cap_eff;
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = TotalBits'(1);
    end else if (TotalBits'(cap_q) > TotalBits'(MaxEntries)) begin
      cap_eff = TotalBits'(MaxEntries);
    end else begin
      cap_eff = TotalBits'(cap_q);
    end
  end

  // Control and item state.
  state_e               state_q, state_d;
  logic [TotalBits-1:0] total_q, total_d;
  logic [SlotBits-1:0]  order_q [MaxEntries];  // rank -> physical slot
  logic [SlotBits-1:0]  order_d [MaxEntries];
  logic [TotalBits-1:0] rd_rank_q, rd_rank_d;  // next rank to fetch
  logic                 cmp_valid_q, cmp_valid_d;
  logic [SlotBits-1:0]  cmp_rank_q, cmp_rank_d; // rank of the word in the read regs
  logic                 clr_q, clr_d;
  logic [KeyBits-1:0]   key_q, key_d;
  logic                 hit_q, hit_d;
  logic [SlotBits-1:0]  pos_q, pos_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic [KeyBits-1:0]   last_key_q, last_key_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic [OutDataBits-1:0] out_data_q, out_data_d;
  logic [OutUserBits-1:0] out_user_q, out_user_d;

  // Key and count memories, indexed by physical slot.
  logic [KeyBits-1:0]   key_mem [MaxEntries];
  logic [CountBits-1:0] cnt_mem [MaxEntries];
  logic [KeyBits-1:0]   rd_key_q;
  logic [CountBits-1:0] rd_cnt_q;
  logic                 mem_rd_en;
  logic                 key_wr_en, cnt_wr_en;
  logic [CountBits-1:0] cnt_wr_data;

  // Addressed read of the order table: scan rank, or in the update step the
  // rank that is hit or that a miss fills; it is written and may move to the front.
  logic [SlotBits-1:0] ord_addr;
  logic [SlotBits-1:0] ord_sel;
  logic                evict;
  logic [SlotBits-1:0] miss_m;
  logic [SlotBits-1:0] rot_m;
  logic                rot_en;
  logic [CountBits-1:0] cnt_inc;
  logic                promote;
  logic                upd_fire;
  logic [TotalBits-1:0] occ;

  assign evict   = (total_q >= cap_eff);
  assign miss_m  = evict ? SlotBits'(total_q - TotalBits'(1)) : total_q[SlotBits-1:0];
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + CountBits'(1);
  assign promote = (cnt_inc > CountBits'(thr_q)) && (pos_q != '0);

  always_comb begin
    if (state_q == StScan) begin
      ord_addr = rd_rank_q[SlotBits-1:0];
    end else if (hit_q) begin
      ord_addr = pos_q;
    end else begin
      ord_addr = miss_m;
    end
  end
  assign ord_sel = order_q[ord_addr];

  assign s_axis_tready = (state_q == StIdle);
  assign upd_fire      = (state_q == StUpd) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (mem_rd_en) begin
      rd_key_q <= key_mem[ord_sel];
      rd_cnt_q <= cnt_mem[ord_sel];
    end
    if (key_wr_en) begin
      key_mem[ord_sel] <= key_q;
    end
    if (cnt_wr_en) begin
      cnt_mem[ord_sel] <= cnt_wr_data;
    end
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    rd_rank_d   = rd_rank_q;
    cmp_valid_d = cmp_valid_q;
    cmp_rank_d  = cmp_rank_q;
    clr_d       = clr_q;
    key_d       = key_q;
    hit_d       = hit_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    last_key_d  = last_key_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    mem_rd_en   = 1'b0;
    key_wr_en   = 1'b0;
    cnt_wr_en   = 1'b0;
    cnt_wr_data = cnt_inc;
    rot_en      = 1'b0;
    rot_m       = ord_addr;
    occ         = total_q;

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          key_d       = s_axis_tdata;
          clr_d       = (s_axis_tuser == CmdClear);
          hit_d       = 1'b0;
          rd_rank_d   = '0;
          cmp_valid_d = 1'b0;
          // clear and an empty list need no search
          if ((s_axis_tuser == CmdClear) || (total_q == '0)) begin
            state_d = StUpd;
          end else begin
            state_d = StScan;
          end
        end
      end

      StScan: begin
        // fetch the next rank while comparing the previous one
        if (rd_rank_q < total_q) begin
          mem_rd_en   = 1'b1;
          cmp_valid_d = 1'b1;
          cmp_rank_d  = rd_rank_q[SlotBits-1:0];
          rd_rank_d   = rd_rank_q + TotalBits'(1);
        end else begin
          cmp_valid_d = 1'b0;
        end
        if (cmp_valid_q) begin
          if (rd_key_q == key_q) begin
            hit_d       = 1'b1;
            pos_d       = cmp_rank_q;
            cnt_d       = rd_cnt_q;
            cmp_valid_d = 1'b0;
            state_d     = StUpd;
          end else if (TotalBits'(cmp_rank_q) == total_q - TotalBits'(1)) begin
            // last entry seen: miss; keep its key in case it gets evicted
            hit_d       = 1'b0;
            last_key_d  = rd_key_q;
            cmp_valid_d = 1'b0;
            state_d     = StUpd;
          end
        end
      end

      StUpd: begin
        if (upd_fire) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
          if (clr_q) begin
            total_d    = '0;
            out_data_d = '0;
            out_user_d = '0;
          end else if (hit_q) begin
            cnt_wr_en  = 1'b1;
            rot_en     = promote;
            out_data_d = {OutPadBits'(0), total_q, KeyBits'(0), cnt_inc};
            out_user_d = '0;
            out_user_d[UserHit]      = 1'b1;
            out_user_d[UserPromoted] = promote;
          end else begin
            // new key goes to the front, into a free slot or the evicted one
            key_wr_en   = 1'b1;
            cnt_wr_en   = 1'b1;
            cnt_wr_data = CountBits'(1);
            rot_en      = 1'b1;
            occ         = TotalBits'(miss_m) + TotalBits'(1);
            total_d     = occ;
            out_data_d  = {OutPadBits'(0), occ, (evict ? last_key_q : KeyBits'(0)),
                           CountBits'(1)};
            out_user_d  = '0;
            out_user_d[UserEvicted] = evict;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Move rank rot_m to the front; ranks ahead of it shift back by one.
  always_comb begin
    for (int i = 0; i < MaxEntries; i++) begin
      order_d[i] = order_q[i];
      if (rot_en) begin
        if (i == 0) begin
          order_d[i] = ord_sel;
        end else if (SlotBits'(i) <= rot_m) begin
          order_d[i] = order_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      total_q     <= '0;
      rd_rank_q   <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxEntries; i++) begin
        order_q[i] <= SlotBits'(i);
      end
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      rd_rank_q   <= rd_rank_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < MaxEntries; i++) begin
        order_q[i] <= order_d[i];
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    cmp_rank_q <= cmp_rank_d;
    clr_q      <= clr_d;
    key_q      <= key_d;
    hit_q      <= hit_d;
    pos_q      <= pos_d;
    cnt_q      <= cnt_d;
    last_key_q <= last_key_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

/* rtl/tpcl_checker.sv */
`default_nettype none

module tpcl_checker (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               cfg_valid_i,
  input wire                               cfg_ready_o,
  input wire                               cfg_index_i,
  input wire [tpcl_pkg::CfgBits-1:0]       cfg_data_i,
  input wire                               s_axis_tvalid,
  input wire                               s_axis_tready,
  input wire [tpcl_pkg::KeyBits-1:0]       s_axis_tdata,
  input wire                               s_axis_tuser,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [tpcl_pkg::OutDataBits-1:0]   m_axis_tdata,
  input wire [tpcl_pkg::OutUserBits-1:0]   m_axis_tuser
);
  import tpcl_pkg::*;

  // hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // a promotion only follows a hit and never comes with an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[UserPromoted] |-> m_axis_tuser[UserHit] &&
      !m_axis_tuser[UserEvicted])
    else $error("promotion without hit");

  // a miss reports count 1, a clear count 0 and an empty list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[UserHit] |->
      (m_axis_tdata[CountBits-1:0] == CountBits'(1)) ||
      ((m_axis_tdata[CountBits-1:0] == '0) &&
       (m_axis_tdata[OccLsb +: TotalBits] == '0)))
    else $error("bad count on miss or clear");

  // occupancy never exceeds the list depth; hits report a count of at least 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OccLsb +: TotalBits] <= TotalBits'(MaxEntries)) &&
      (!m_axis_tuser[UserHit] || (m_axis_tdata[CountBits-1:0] != '0)))
    else $error("occupancy or hit count out of range");

  // configuration writes are never refused
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind threshold_promote_cache_list tpcl_checker u_tpcl_checker (.*);

`default_nettype wire
